[rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// Template tag scanner package
// Shared types, constants and scan table for the template tag scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    // Position counter and operator store sizing
    localparam int POS_BITS    = 16;
    localparam int OP_DEPTH    = 5;
    localparam int OP_IDX_BITS = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
    localparam int OP_CNT_BITS = $clog2(OP_DEPTH + 1);
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Result queue sizing
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef logic [POS_BITS-1:0] t_pos;

    // Result kinds
    localparam logic [2:0] K_EXPR   = 3'd0;
    localparam logic [2:0] K_DECLS  = 3'd1;
    localparam logic [2:0] K_STMTS  = 3'd2;
    localparam logic [2:0] K_SEG    = 3'd3;
    localparam logic [2:0] K_ASSIGN = 3'd4;
    localparam logic [2:0] K_APPEND = 3'd5;
    localparam logic [2:0] K_TEXT   = 3'd6;

    // Group marks (subset of kinds)
    localparam logic [1:0] G_EXPR  = 2'd0;
    localparam logic [1:0] G_DECLS = 2'd1;
    localparam logic [1:0] G_STMTS = 2'd2;

    // Scan states
    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_ARG     = 3'd1;
    localparam logic [2:0] ST_WHITE   = 3'd2;
    localparam logic [2:0] ST_OP      = 3'd3;
    localparam logic [2:0] ST_OPWHITE = 3'd4;
    localparam logic [2:0] ST_BAR     = 3'd5;

    // Byte classes
    localparam logic [2:0] CL_WHITE = 3'd0;
    localparam logic [2:0] CL_BAR   = 3'd1;
    localparam logic [2:0] CL_OP    = 3'd2;
    localparam logic [2:0] CL_GROUP = 3'd3;
    localparam logic [2:0] CL_OTHER = 3'd4;

    // Scan actions
    localparam logic [3:0] ACT_NONE     = 4'd0;
    localparam logic [3:0] ACT_ARG_BOTH = 4'd1;
    localparam logic [3:0] ACT_ARG_BEG  = 4'd2;
    localparam logic [3:0] ACT_GROUP    = 4'd3;
    localparam logic [3:0] ACT_ARG_END  = 4'd4;
    localparam logic [3:0] ACT_END_OP   = 4'd5;
    localparam logic [3:0] ACT_OP_NEW   = 4'd6;
    localparam logic [3:0] ACT_OP_ADD   = 4'd7;
    localparam logic [3:0] ACT_CLOSE    = 4'd8;

    // Characters
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FF    = 8'h0C;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] text_start;
        logic [15:0] text_end;
        logic [15:0] arg_start;
        logic [15:0] arg_end;
        logic        closed;
        logic        final_res;
    } t_out_item;

    typedef struct packed {
        logic [3:0] act;
        logic [2:0] nxt;
    } t_move;

    // Sort a tag byte into its class
    function automatic logic [2:0] classify(input logic [7:0] c);
        logic [2:0] cls;
        if (c inside {CH_SP, CH_NL, CH_TAB, CH_CR, CH_FF}) cls = CL_WHITE;
        else if (c == CH_BAR) cls = CL_BAR;
        else if (c inside {CH_TILDE, CH_COLON, CH_EQ}) cls = CL_OP;
        else if (c inside {CH_BANG, CH_DOLL}) cls = CL_GROUP;
        else cls = CL_OTHER;
        return cls;
    endfunction

    // Scan table: action and next state per state and class
    function automatic t_move scan_move(input logic [2:0] st, input logic [2:0] cls);
        t_move m;
        m = '{act: ACT_NONE, nxt: ST_ARG};
        case (st)
            ST_ARG: begin
                case (cls)
                    CL_WHITE: m = '{act: ACT_ARG_END, nxt: ST_WHITE};
                    CL_BAR:   m = '{act: ACT_ARG_END, nxt: ST_BAR};
                    CL_OP:    m = '{act: ACT_END_OP,  nxt: ST_OP};
                    default:  m = '{act: ACT_NONE,    nxt: ST_ARG};
                endcase
            end
            ST_WHITE: begin
                case (cls)
                    CL_WHITE: m = '{act: ACT_NONE,   nxt: ST_WHITE};
                    CL_BAR:   m = '{act: ACT_NONE,   nxt: ST_BAR};
                    CL_OP:    m = '{act: ACT_OP_NEW, nxt: ST_OP};
                    default:  m = '{act: ACT_NONE,   nxt: ST_ARG};
                endcase
            end
            ST_OP: begin
                case (cls)
                    CL_WHITE: m = '{act: ACT_NONE,   nxt: ST_OPWHITE};
                    CL_BAR:   m = '{act: ACT_NONE,   nxt: ST_BAR};
                    CL_OP:    m = '{act: ACT_OP_ADD, nxt: ST_OP};
                    default:  m = '{act: ACT_NONE,   nxt: ST_ARG};
                endcase
            end
            ST_OPWHITE: begin
                case (cls)
                    CL_WHITE: m = '{act: ACT_NONE,   nxt: ST_OPWHITE};
                    CL_BAR:   m = '{act: ACT_NONE,   nxt: ST_BAR};
                    CL_OP:    m = '{act: ACT_OP_NEW, nxt: ST_OP};
                    default:  m = '{act: ACT_NONE,   nxt: ST_ARG};
                endcase
            end
            ST_BAR: begin
                case (cls)
                    CL_WHITE: m = '{act: ACT_ARG_END, nxt: ST_WHITE};
                    CL_BAR:   m = '{act: ACT_NONE,    nxt: ST_BAR};
                    CL_OP:    m = '{act: ACT_END_OP,  nxt: ST_OP};
                    CL_GROUP: m = '{act: ACT_NONE,    nxt: ST_ARG};
                    default:  m = '{act: ACT_CLOSE,   nxt: ST_ARG};
                endcase
            end
            default: begin
                // initial state, and any unused code
                case (cls)
                    CL_WHITE: m = '{act: ACT_NONE,     nxt: ST_INIT};
                    CL_BAR:   m = '{act: ACT_ARG_BOTH, nxt: ST_BAR};
                    CL_OP:    m = '{act: ACT_ARG_BEG,  nxt: ST_ARG};
                    CL_GROUP: m = '{act: ACT_GROUP,    nxt: ST_INIT};
                    default:  m = '{act: ACT_ARG_BEG,  nxt: ST_ARG};
                endcase
            end
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/template_tag_scanner.sv]
// ----------------------------------------------------------------------------
// Template tag scanner
// Scans template text a byte per beat and reports tag and text spans.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one source
//   byte per beat with a flag on the final byte of a text. Output channel
//   (o_out_valid / i_out_ready / o_out_item) gives tag results and, after
//   the final byte, the trailing text span flagged by final_res.
//   Each accepted byte updates the scan state in the same edge and pushes
//   zero, one or two results into a four-entry result queue; a result is
//   stored at the edge that accepts its byte and offered in queue order.
//   One byte is taken every cycle while the queue has room for two
//   results, so a byte that yields at most one result sustains one byte
//   per cycle if results drain as fast; two-result bytes fill the queue.
//   When the receiver stalls the queue fills and o_in_ready drops once
//   fewer than two entries are free; results are held, none dropped.
//   Reset clears the scan state, the position counter and the queue.
//   After the final byte of a text all scan state returns to its reset
//   values, so the next byte starts a new text at position 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module template_tag_scanner
    import tts_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_item  o_out_item
);

    // Scan state
    logic                   r_in_tag,     n_in_tag;
    logic                   r_pending,    n_pending;
    t_pos                   r_pos,        n_pos;
    t_pos                   r_open_pos,   n_open_pos;
    t_pos                   r_text_begin, n_text_begin;
    t_pos                   r_arg_begin,  n_arg_begin;
    t_pos                   r_arg_stop,   n_arg_stop;
    logic [2:0]             r_scan,       n_scan;
    logic [1:0]             r_group,      n_group;
    logic [7:0]             r_ops [OP_DEPTH];
    logic [7:0]             n_ops [OP_DEPTH];
    logic [OP_CNT_BITS-1:0] r_op_cnt,     n_op_cnt;

    // Result queue
    t_out_item              r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr, r_rd;
    logic [FIFO_CNT_BITS-1:0] r_cnt;

    logic      in_acc, out_acc;
    t_pos      nextp;
    t_move     mv;
    logic      tag_done;
    logic      emit_tag, emit_trail;
    logic [2:0] tag_kind;
    t_out_item res_tag, res_trail, res_a, res_b;
    logic [1:0] push_n;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign nextp   = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign mv      = scan_move(r_scan, classify(i_in_item.ch));

    // Advance the scan state for one byte and build its results
    always_comb begin
        logic [OP_CNT_BITS-1:0] op_base;
        logic                   op_store;
        logic                   op_restart;
        t_pos                   trail_begin;

        n_in_tag     = r_in_tag;
        n_pending    = r_pending;
        n_pos        = r_pos;
        n_open_pos   = r_open_pos;
        n_text_begin = r_text_begin;
        n_arg_begin  = r_arg_begin;
        n_arg_stop   = r_arg_stop;
        n_scan       = r_scan;
        n_group      = r_group;
        n_ops        = r_ops;
        n_op_cnt     = r_op_cnt;
        tag_done     = 1'b0;
        emit_tag     = 1'b0;
        emit_trail   = 1'b0;
        op_store     = 1'b0;
        op_restart   = 1'b0;
        op_base      = '0;
        trail_begin  = r_text_begin;
        tag_kind     = K_EXPR;
        res_tag      = '0;
        res_trail    = '0;

        if (in_acc) begin
            if (!r_in_tag) begin
                // look for the opener with one byte of lookahead
                if (r_pending && i_in_item.ch == CH_BAR) begin
                    n_pending = 1'b0;
                    n_in_tag  = 1'b1;
                    n_scan    = ST_INIT;
                    n_group   = G_EXPR;
                    n_op_cnt  = '0;
                end else if (i_in_item.ch == CH_LT) begin
                    n_pending  = 1'b1;
                    n_open_pos = r_pos;
                end else begin
                    n_pending = 1'b0;
                end
            end else begin
                n_scan = mv.nxt;
                case (mv.act)
                    ACT_ARG_BOTH: begin
                        n_arg_begin = r_pos;
                        n_arg_stop  = r_pos;
                    end
                    ACT_ARG_BEG: n_arg_begin = r_pos;
                    ACT_GROUP:   n_group = (i_in_item.ch == CH_BANG) ? G_DECLS : G_STMTS;
                    ACT_ARG_END: n_arg_stop = r_pos;
                    ACT_END_OP: begin
                        n_arg_stop = r_pos;
                        op_store   = 1'b1;
                        op_restart = 1'b1;
                    end
                    ACT_OP_NEW: begin
                        op_store   = 1'b1;
                        op_restart = 1'b1;
                    end
                    ACT_OP_ADD:  op_store = 1'b1;
                    ACT_CLOSE:   tag_done = (i_in_item.ch == CH_GT);
                    default: ;
                endcase

                // store operator bytes up to the store depth
                if (op_store) begin
                    op_base = op_restart ? '0 : r_op_cnt;
                    if (op_base < OP_CNT_BITS'(OP_DEPTH)) begin
                        n_ops[op_base[OP_IDX_BITS-1:0]] = i_in_item.ch;
                        n_op_cnt = OP_CNT_BITS'(op_base + 1'b1);
                    end else begin
                        n_op_cnt = op_base;
                    end
                end

                if (tag_done) begin
                    n_text_begin = nextp;
                    n_in_tag     = 1'b0;
                    n_scan       = ST_INIT;
                end
            end

            // classify the tag from its group mark or operator string
            if (n_group != G_EXPR) begin
                tag_kind = {1'b0, n_group};
            end else if (n_op_cnt == OP_CNT_BITS'(1) && n_ops[0] == CH_COLON) begin
                tag_kind = K_SEG;
            end else if (n_op_cnt == OP_CNT_BITS'(2) && n_ops[0] == CH_COLON
                         && n_ops[1] == CH_EQ) begin
                tag_kind = K_ASSIGN;
            end else if (n_op_cnt == OP_CNT_BITS'(3) && n_ops[0] == CH_TILDE
                         && n_ops[1] == CH_COLON && n_ops[2] == CH_EQ) begin
                tag_kind = K_APPEND;
            end else begin
                tag_kind = K_EXPR;
            end

            res_tag.kind       = tag_kind;
            res_tag.text_start = 16'(r_text_begin);
            res_tag.text_end   = 16'(n_open_pos);
            res_tag.arg_start  = 16'(n_arg_begin);
            res_tag.arg_end    = 16'(n_arg_stop);
            res_tag.closed     = tag_done;
            res_tag.final_res  = 1'b0;

            emit_tag    = tag_done || (i_in_item.last && n_in_tag);
            trail_begin = (i_in_item.last && n_in_tag) ? nextp : n_text_begin;

            res_trail.kind       = K_TEXT;
            res_trail.text_start = 16'(trail_begin);
            res_trail.text_end   = 16'(nextp);
            res_trail.arg_start  = '0;
            res_trail.arg_end    = '0;
            res_trail.closed     = 1'b0;
            res_trail.final_res  = 1'b1;

            if (i_in_item.last) begin
                // end of text: drop back to the reset state
                emit_trail   = 1'b1;
                n_in_tag     = 1'b0;
                n_pending    = 1'b0;
                n_pos        = '0;
                n_open_pos   = '0;
                n_text_begin = '0;
                n_arg_begin  = '0;
                n_arg_stop   = '0;
                n_scan       = ST_INIT;
                n_group      = G_EXPR;
                n_op_cnt     = '0;
            end else begin
                n_pos = nextp;
            end
        end
    end

    // Order the results of this byte for the queue
    always_comb begin
        res_a  = emit_tag ? res_tag : res_trail;
        res_b  = res_trail;
        push_n = {1'b0, emit_tag} + {1'b0, emit_trail};
    end

    // Hold scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag     <= 1'b0;
            r_pending    <= 1'b0;
            r_pos        <= '0;
            r_open_pos   <= '0;
            r_text_begin <= '0;
            r_arg_begin  <= '0;
            r_arg_stop   <= '0;
            r_scan       <= ST_INIT;
            r_group      <= G_EXPR;
            r_op_cnt     <= '0;
        end else begin
            r_in_tag     <= n_in_tag;
            r_pending    <= n_pending;
            r_pos        <= n_pos;
            r_open_pos   <= n_open_pos;
            r_text_begin <= n_text_begin;
            r_arg_begin  <= n_arg_begin;
            r_arg_stop   <= n_arg_stop;
            r_scan       <= n_scan;
            r_group      <= n_group;
            r_op_cnt     <= n_op_cnt;
        end
    end

    // Operator bytes are payload only: the count gates every read
    always_ff @(posedge i_clk) begin
        r_ops <= n_ops;
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr] <= res_a;
        end
        if (push_n == 2'd2) begin
            r_fifo[FIFO_PTR_BITS'(r_wr + 1'b1)] <= res_b;
        end
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= FIFO_PTR_BITS'(r_wr + push_n);
            r_rd  <= FIFO_PTR_BITS'(r_rd + out_acc);
            r_cnt <= FIFO_CNT_BITS'(r_cnt + push_n - out_acc);
        end
    end

    assign o_in_ready  = (r_cnt <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign o_out_valid = (r_cnt != '0);
    assign o_out_item  = r_fifo[r_rd];

    // Queue occupancy never exceeds its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue overflow");

    // The final byte of a text always leaves a result to send
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.last |=> o_out_valid)
        else $error("no result after final byte");

    // The final byte of a text restarts the position count outside a tag
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.last |=> (r_pos == '0) && !r_in_tag && !r_pending)
        else $error("scan state not restarted after final byte");

endmodule

`default_nettype wire
